FILE: rtl/dam_pkg.sv
// Shared types, codes and constant-divide helper for the dwelling address matcher.
`default_nettype none

package dam_pkg;

    // Command codes carried on the input tuser.
    typedef enum logic [1:0] {
        OP_DIAL = 2'd0,
        OP_SET  = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Reply codes carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_CALL  = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_REPLY = 2'd2
    } kind_t;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_BRANCH_ADDRESS = 1'b0;
    localparam logic REG_DIRECT_MODE    = 1'b1;

    // Floor reciprocals of 2^16 for the constant divisors used in replies.
    localparam logic [16:0] RECIP_100 = 17'(65536 / 100);
    localparam logic [16:0] RECIP_10  = 17'(65536 / 10);
    localparam logic [7:0]  DIV_100   = 8'd100;
    localparam logic [7:0]  DIV_10    = 8'd10;

    // Dial number and its hardware-rule decomposition.
    typedef struct packed {
        logic [15:0] dial;
        logic        hw_ok;
        logic [7:0]  base;
        logic [2:0]  slot_rem;
    } dial_info_t;

    // Match and lookup results of the home bank.
    typedef struct packed {
        logic        hit;
        logic [2:0]  hit_slot;
        logic        rd_set;
        logic [15:0] rd_number;
    } bank_result_t;

    // Unsigned 16-bit divide by a small constant d, given m = floor(2^16 / d).
    // The estimate is low by at most one, so a single correction step fixes it.
    // Returns {quotient, remainder}.
    function automatic logic [31:0] div_const16(input logic [15:0] x,
                                                input logic [7:0]  d,
                                                input logic [16:0] m);
        logic [32:0] prod;
        logic [15:0] q0;
        logic [23:0] back;
        logic [16:0] r0;
        logic [15:0] q;
        logic [16:0] r;
        prod = 33'(x) * 33'(m);
        q0   = prod[31:16];
        back = 24'(q0) * 24'(d);
        r0   = {1'b0, x} - back[16:0];
        if (r0 >= 17'(d))
        begin
            q = q0 + 16'd1;
            r = r0 - 17'(d);
        end
        else
        begin
            q = q0;
            r = r0;
        end
        return {q, r[15:0]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dam_dial_conv.sv
// Dial number assembly and hardware-rule base and slot decomposition.
`default_nettype none

module dam_dial_conv #(
    parameter int HOMES_PER_BRANCH = 4
) (
    input  wire logic [7:0]          arg_a,
    input  wire logic [7:0]          arg_b,
    input  wire logic [7:0]          arg_c,
    input  wire logic [7:0]          arg_d,
    input  wire logic                direct_mode,
    output dam_pkg::dial_info_t      info
);

    localparam logic [16:0] RECIP_H = 17'(65536 / HOMES_PER_BRANCH);
    localparam logic [7:0]  DIV_H   = 8'(HOMES_PER_BRANCH);

    logic [15:0] dial;
    logic [7:0]  floor_num;
    logic [7:0]  room_num;
    logic [15:0] conv;
    logic [15:0] conv_m1;
    logic [31:0] qr;

    always_comb
    begin
        // Dial arithmetic wraps at 16 bits, matching the dial register width; floor and room numbers wrap at 8 bits.
        dial = 16'(arg_a) * 16'd1000 + 16'(arg_b) * 16'd100
             + 16'(arg_c) * 16'd10 + 16'(arg_d);
        floor_num = arg_a * 8'd10 + arg_b;
        room_num  = arg_c * 8'd10 + arg_d;
        if (direct_mode)
            conv = dial;
        else
            conv = 16'(floor_num) * 16'd10 + 16'(room_num) - 16'd10;
        conv_m1 = conv - 16'd1;
        qr = dam_pkg::div_const16(conv_m1, DIV_H, RECIP_H);

        info.dial     = dial;
        info.hw_ok    = (conv != 16'd0);
        info.base     = qr[23:16];
        info.slot_rem = qr[2:0];
    end

endmodule

`default_nettype wire

FILE: rtl/dam_home_bank.sv
// Stored home numbers, per-home match logic and selector lookup.
`default_nettype none

module dam_home_bank #(
    parameter int HOMES_PER_BRANCH = 4,
    parameter int IDX_W            = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_sel,
    input  wire logic [15:0]          wr_number,
    input  wire logic [IDX_W-1:0]     rd_sel,
    input  wire dam_pkg::dial_info_t  info,
    input  wire logic [7:0]           branch_address,
    output dam_pkg::bank_result_t     result
);

    logic [15:0]                 number_reg [HOMES_PER_BRANCH];
    logic [HOMES_PER_BRANCH-1:0] set_reg;
    logic [HOMES_PER_BRANCH-1:0] set_next;
    logic [HOMES_PER_BRANCH-1:0] hit_vec;

    always_comb
    begin
        set_next = set_reg;
        for (int i = 0; i < HOMES_PER_BRANCH; i++)
        begin
            if (wr_en && (wr_sel == IDX_W'(i)))
                set_next[i] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            set_reg <= '0;
        else
            set_reg <= set_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HOMES_PER_BRANCH; i++)
        begin
            if (wr_en && (wr_sel == IDX_W'(i)))
                number_reg[i] <= wr_number;
        end
    end

    // A set home matches on its stored number; an unset home follows the
    // hardware rule of branch base plus slot.
    always_comb
    begin
        for (int i = 0; i < HOMES_PER_BRANCH; i++)
        begin
            if (set_reg[i])
                hit_vec[i] = (info.dial == number_reg[i]);
            else
                hit_vec[i] = info.hw_ok && (info.base == branch_address)
                           && (info.slot_rem == 3'(i));
        end
    end

    always_comb
    begin
        result.hit       = 1'b0;
        result.hit_slot  = 3'd0;
        result.rd_set    = 1'b0;
        result.rd_number = 16'd0;
        // Walk downward so the lowest-numbered home wins.
        for (int i = HOMES_PER_BRANCH - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                result.hit      = 1'b1;
                result.hit_slot = 3'(i + 1);
            end
        end
        for (int i = 0; i < HOMES_PER_BRANCH; i++)
        begin
            if (rd_sel == IDX_W'(i))
            begin
                result.rd_set    = set_reg[i];
                result.rd_number = number_reg[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dam_reply.sv
// Home number reply formatting from a stored or a derived number.
`default_nettype none

module dam_reply #(
    parameter int HOMES_PER_BRANCH = 4
) (
    input  wire logic        rd_set,
    input  wire logic [15:0] rd_number,
    input  wire logic [7:0]  branch_address,
    input  wire logic        direct_mode,
    input  wire logic [7:0]  home_sel,
    output logic      [7:0]  reply_high,
    output logic      [7:0]  reply_low
);

    logic [15:0] derived;
    logic [15:0] dividend_100;
    logic [31:0] qr_100;
    logic [31:0] qr_10;

    always_comb
    begin
        derived      = 16'(branch_address) * 16'(HOMES_PER_BRANCH) + 16'(home_sel);
        dividend_100 = rd_set ? rd_number : derived;
        qr_100 = dam_pkg::div_const16(dividend_100, dam_pkg::DIV_100, dam_pkg::RECIP_100);
        qr_10  = dam_pkg::div_const16(derived - 16'd1, dam_pkg::DIV_10, dam_pkg::RECIP_10);

        // Floor and room form numbers floors and rooms from one.
        if (rd_set || direct_mode)
        begin
            reply_high = qr_100[23:16];
            reply_low  = qr_100[7:0];
        end
        else
        begin
            reply_high = qr_10[23:16] + 8'd1;
            reply_low  = qr_10[7:0] + 8'd1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dwelling_address_matcher.sv
// Top level of the dwelling address matcher: handshakes, registers and command decode.
// Usage:
// Commands arrive on the s_axis channel, one word per command, with the opcode in
// tuser and the four argument bytes in tdata. Results leave on the m_axis channel
// with the reply kind in tuser and the home slot and reply bytes in tdata. A command
// that produces no result (a dial with no match, a set or read for another branch,
// a read with a bad selector, or the unused opcode) simply retires.
// A word accepted into the input register is evaluated in a single pass against the
// stored home numbers, and its result is loaded into the output register when the
// word leaves the input register.
// A new command can be accepted every cycle; s_axis_tready drops only when a result
// waits in the output register, the receiver holds m_axis_tready low, and the word
// in the input register also has a result to deliver.
// A set command updates the home store when it leaves the input register, so the
// command right behind it already sees the new number.
// Reset clears both handshake registers, the branch address, the dial mode and all
// home-is-set flags, so every home starts out on the hardware address rule.
// The APB port writes branch_address at byte address 0 and direct_number_mode at 4;
// it is meant to be written only while no command is in flight.
`default_nettype none

module dwelling_address_matcher #(
    parameter int HOMES_PER_BRANCH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // arg_a[7:0], arg_b[15:8], arg_c[23:16], arg_d[31:24]
    input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // home_slot[2:0], reply_high[10:3],
                                            // reply_low[18:11], zero[23:19]
    output logic      [1:0]  m_axis_tuser   // reply_kind[1:0]
);

    localparam int IDX_W = (HOMES_PER_BRANCH > 1) ? $clog2(HOMES_PER_BRANCH) : 1;

    // Configuration registers.
    logic [7:0] branch_reg;
    logic       direct_reg;
    logic       cfg_write;

    // Input register.
    logic         in_valid_reg;
    dam_pkg::op_t op_reg;
    logic [7:0]   a_reg;
    logic [7:0]   b_reg;
    logic [7:0]   c_reg;
    logic [7:0]   d_reg;

    // Output register.
    logic          out_valid_reg;
    dam_pkg::kind_t kind_reg;
    logic [2:0]    slot_reg;
    logic [7:0]    high_reg;
    logic [7:0]    low_reg;

    // Evaluation of the word in the input register.
    dam_pkg::dial_info_t   info;
    dam_pkg::bank_result_t bank;
    logic [7:0]            rep_high;
    logic [7:0]            rep_low;
    logic                  sel_ok;
    logic [IDX_W-1:0]      sel_idx;
    logic                  has_result;
    logic                  wr_req;
    logic                  advance;
    dam_pkg::kind_t        kind_next;
    logic [2:0]            slot_next;
    logic [7:0]            high_next;
    logic [7:0]            low_next;

    // APB: no wait states; writes decode on address bit 2 only.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_reg <= 8'd0;
            direct_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                dam_pkg::REG_BRANCH_ADDRESS: branch_reg <= pwdata[7:0];
                dam_pkg::REG_DIRECT_MODE:    direct_reg <= pwdata[0];
                default:                     branch_reg <= branch_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            dam_pkg::REG_BRANCH_ADDRESS: prdata = {24'd0, branch_reg};
            dam_pkg::REG_DIRECT_MODE:    prdata = {31'd0, direct_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    dam_dial_conv #(
        .HOMES_PER_BRANCH (HOMES_PER_BRANCH)
    ) u_dial_conv (
        .arg_a       (a_reg),
        .arg_b       (b_reg),
        .arg_c       (c_reg),
        .arg_d       (d_reg),
        .direct_mode (direct_reg),
        .info        (info)
    );

    dam_home_bank #(
        .HOMES_PER_BRANCH (HOMES_PER_BRANCH),
        .IDX_W            (IDX_W)
    ) u_home_bank (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (advance && wr_req),
        .wr_sel         (sel_idx),
        .wr_number      ({b_reg, c_reg}),
        .rd_sel         (sel_idx),
        .info           (info),
        .branch_address (branch_reg),
        .result         (bank)
    );

    dam_reply #(
        .HOMES_PER_BRANCH (HOMES_PER_BRANCH)
    ) u_reply (
        .rd_set         (bank.rd_set),
        .rd_number      (bank.rd_number),
        .branch_address (branch_reg),
        .direct_mode    (direct_reg),
        .home_sel       (a_reg),
        .reply_high     (rep_high),
        .reply_low      (rep_low)
    );

    // Command decode. A set whose selector is out of range still acknowledges.
    always_comb
    begin
        sel_ok     = (a_reg >= 8'd1) && (a_reg <= 8'(HOMES_PER_BRANCH));
        sel_idx    = IDX_W'(a_reg - 8'd1);
        has_result = 1'b0;
        wr_req     = 1'b0;
        kind_next  = dam_pkg::KIND_CALL;
        slot_next  = 3'd0;
        high_next  = 8'd0;
        low_next   = 8'd0;
        unique case (op_reg)
            dam_pkg::OP_DIAL:
            begin
                has_result = bank.hit;
                kind_next  = dam_pkg::KIND_CALL;
                slot_next  = bank.hit_slot;
            end
            dam_pkg::OP_SET:
            begin
                has_result = (d_reg == branch_reg);
                wr_req     = (d_reg == branch_reg) && sel_ok;
                kind_next  = dam_pkg::KIND_ACK;
            end
            dam_pkg::OP_READ:
            begin
                has_result = (b_reg == branch_reg) && sel_ok;
                kind_next  = dam_pkg::KIND_REPLY;
                slot_next  = a_reg[2:0];
                high_next  = rep_high;
                low_next   = rep_low;
            end
            dam_pkg::OP_NONE:
            begin
                has_result = 1'b0;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // The word in the input register leaves when it has no result or the
    // output register is free or being emptied this cycle.
    assign advance       = in_valid_reg && (!has_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg <= dam_pkg::op_t'(s_axis_tuser);
            a_reg  <= s_axis_tdata[7:0];
            b_reg  <= s_axis_tdata[15:8];
            c_reg  <= s_axis_tdata[23:16];
            d_reg  <= s_axis_tdata[31:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && has_result)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            kind_reg <= kind_next;
            slot_reg <= slot_next;
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {5'd0, low_reg, high_reg, slot_reg};

endmodule

`default_nettype wire
